// File: src/mrfh_pkg.sv
`default_nettype none
package mrfh_pkg;

    // Fixed field widths of the channels
    localparam int VALUE_FIELDS  = 4;
    localparam int VALUE_W       = 4;
    localparam int SIZE_W        = 4;
    localparam int NV_W          = 3;
    localparam int INDEX_W       = 12;
    localparam int COUNT_FIELD_W = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 4;

    // Internal arithmetic widths (sizes are at most 15)
    localparam int STRIDE_W  = 12;   // 15^3 = 3375
    localparam int PROD_W    = 16;   // 14 * 3375
    localparam int IDX_W     = 18;   // sum of products, also holds NUM_BINS
    localparam int CNT_EXT_W = 32;   // widest count

    // Cycles for the stride chain to follow a config write
    localparam int SETTLE_W = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYC = SETTLE_W'(VALUE_FIELDS - 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_3   = 3'd4;

    // Register reset values
    localparam logic [NV_W-1:0]   RST_NUM_VARS = 3'd1;
    localparam logic [SIZE_W-1:0] RST_SIZE     = 4'd2;

    // Operation codes
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Parameter defaults
    localparam int DEF_MAX_VARS   = 4;
    localparam int DEF_NUM_BINS   = 4096;
    localparam int DEF_COUNT_BITS = 16;

    // Bin request from the index unit to the count unit
    typedef struct packed {
        logic             op;
        logic             bad;
        logic [IDX_W-1:0] idx;
    } t_req;

endpackage
`default_nettype wire

// File: src/mrfh_if.sv
`default_nettype none
// Sample channel
interface mrfh_in_if import mrfh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [VALUE_W-1:0] value_0;
    logic [VALUE_W-1:0] value_1;
    logic [VALUE_W-1:0] value_2;
    logic [VALUE_W-1:0] value_3;
    logic [INDEX_W-1:0] read_bin;

    modport source (output valid, op, value_0, value_1, value_2, value_3, read_bin,
                    input ready);
    modport sink   (input valid, op, value_0, value_1, value_2, value_3, read_bin,
                    output ready);
endinterface

// Result channel
interface mrfh_out_if import mrfh_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [INDEX_W-1:0]       bin_index;
    logic [COUNT_FIELD_W-1:0] bin_count;
    logic                     bad_value;

    modport source (output valid, bin_index, bin_count, bad_value, input ready);
    modport sink   (input valid, bin_index, bin_count, bad_value, output ready);
endinterface

// Config write channel
interface mrfh_cfg_if import mrfh_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/mixed_radix_family_histogram.sv
`default_nettype none
// Channel   Dir  Beat contents
// i_cfg     in   index (register), data
// i_sample  in   op, value_0..value_3, read_bin
// o_result  out  bin_index, bin_count, bad_value
//
// One beat per cycle sustained while o_result is ready; a result passes the product, sum,
// read and output registers after its sample beat.
// The rate is set by the single bin-memory read-modify-write, with forwarding.
// After reset a clearing pass writes zero to every bin; i_sample is held off meanwhile.
// A config write holds off i_sample while the stride chain settles.
// A stalled o_result holds its beat; the stages behind it keep filling.
module mixed_radix_family_histogram import mrfh_pkg::*; #(
    parameter int MAX_VARS   = DEF_MAX_VARS,
    parameter int NUM_BINS   = DEF_NUM_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrfh_cfg_if.sink   i_cfg,
    mrfh_in_if.sink    i_sample,
    mrfh_out_if.source o_result
);

    logic req_valid;
    logic req_ready;
    t_req req;
    logic busy;

    mrfh_index #(
        .MAX_VARS (MAX_VARS),
        .NUM_BINS (NUM_BINS)
    ) u_index (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_sample    (i_sample),
        .i_busy      (busy),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    mrfh_count #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_count (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_busy      (busy),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

// File: src/mrfh_ram.sv
`default_nettype none
// Simple dual-port RAM, one write and one registered read port
module mrfh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-first on an address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: src/mrfh_index.sv
`default_nettype none
// Config registers, stride chain and two-stage bin index computation
module mrfh_index import mrfh_pkg::*; #(
    parameter int MAX_VARS = DEF_MAX_VARS,
    parameter int NUM_BINS = DEF_NUM_BINS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mrfh_cfg_if.sink  i_cfg,
    mrfh_in_if.sink   i_sample,
    input  wire logic i_busy,
    output logic      o_req_valid,
    output t_req      o_req,
    input  wire logic i_req_ready
);

    localparam int LIM = (MAX_VARS < VALUE_FIELDS) ? MAX_VARS : VALUE_FIELDS;

    logic [NV_W-1:0]     r_num_vars;
    logic [SIZE_W-1:0]   r_size   [VALUE_FIELDS];
    logic [STRIDE_W-1:0] r_stride [VALUE_FIELDS];
    logic [SETTLE_W-1:0] r_settle;

    logic                cfg_wr;
    logic                accept;
    logic [NV_W-1:0]     n_use;
    logic [VALUE_W-1:0]  vals     [VALUE_FIELDS];
    logic                n_p_bad;
    logic [PROD_W-1:0]   n_p_prod [VALUE_FIELDS];

    // product stage
    logic                r_p_valid;
    logic                r_p_op;
    logic                r_p_bad;
    logic [PROD_W-1:0]   r_p_prod [VALUE_FIELDS];
    logic [INDEX_W-1:0]  r_p_rb;

    // sum stage
    logic                r_a_valid;
    t_req                r_a;
    t_req                n_a;
    logic [IDX_W-1:0]    sum;

    logic                a_free;
    logic                p_free;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars <= RST_NUM_VARS;
            for (int i = 0; i < VALUE_FIELDS; i++) begin
                r_size[i] <= RST_SIZE;
            end
        end else if (cfg_wr) begin
            case (i_cfg.index)
                CFG_NUM_VARS: r_num_vars <= i_cfg.data[NV_W-1:0];
                CFG_SIZE_0:   r_size[0]  <= i_cfg.data;
                CFG_SIZE_1:   r_size[1]  <= i_cfg.data;
                CFG_SIZE_2:   r_size[2]  <= i_cfg.data;
                CFG_SIZE_3:   r_size[3]  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // stride chain: one product per stage, settles stage by stage after a write
    always_ff @(posedge i_clk) begin
        r_stride[0] <= STRIDE_W'(1);
        for (int i = 1; i < VALUE_FIELDS; i++) begin
            r_stride[i] <= STRIDE_W'(PROD_W'(r_stride[i-1]) * PROD_W'(r_size[i-1]));
        end
    end

    // hold off samples while the strides settle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= '0;
        end else if (cfg_wr) begin
            r_settle <= SETTLE_CYC;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - SETTLE_W'(1);
        end
    end

    // variables in use, clamped to 1..LIM
    always_comb begin
        n_use = r_num_vars;
        if (n_use == '0) begin
            n_use = NV_W'(1);
        end
        if (n_use > NV_W'(LIM)) begin
            n_use = NV_W'(LIM);
        end
    end

    assign vals[0] = i_sample.value_0;
    assign vals[1] = i_sample.value_1;
    assign vals[2] = i_sample.value_2;
    assign vals[3] = i_sample.value_3;

    // range check and per-variable product
    always_comb begin
        n_p_bad = 1'b0;
        for (int i = 0; i < VALUE_FIELDS; i++) begin
            n_p_prod[i] = '0;
            if (i < int'(n_use)) begin
                if (vals[i] == '0 || vals[i] > r_size[i]) begin
                    n_p_bad = 1'b1;
                end
                n_p_prod[i] = PROD_W'(vals[i] - VALUE_W'(1)) * PROD_W'(r_stride[i]);
            end
        end
    end

    assign a_free         = !r_a_valid || i_req_ready;
    assign p_free         = !r_p_valid || a_free;
    assign i_sample.ready = p_free && !i_busy && (r_settle == '0);
    assign accept         = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_free) begin
            r_p_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_free && accept) begin
            r_p_op  <= i_sample.op;
            r_p_bad <= n_p_bad;
            r_p_rb  <= i_sample.read_bin;
            for (int i = 0; i < VALUE_FIELDS; i++) begin
                r_p_prod[i] <= n_p_prod[i];
            end
        end
    end

    // sum of products and table bound
    always_comb begin
        sum = '0;
        for (int i = 0; i < VALUE_FIELDS; i++) begin
            sum = sum + IDX_W'(r_p_prod[i]);
        end
        n_a.op = r_p_op;
        if (r_p_op == OP_READ) begin
            n_a.idx = IDX_W'(r_p_rb);
            n_a.bad = (IDX_W'(r_p_rb) >= IDX_W'(NUM_BINS));
        end else begin
            n_a.bad = r_p_bad || (sum >= IDX_W'(NUM_BINS));
            n_a.idx = n_a.bad ? '0 : sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && r_p_valid) begin
            r_a <= n_a;
        end
    end

    assign o_req_valid = r_a_valid;
    assign o_req       = r_a;

    a_no_accept_settling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settle != '0) |-> !accept)
        else $error("sample accepted while strides settle");

endmodule
`default_nettype wire

// File: src/mrfh_count.sv
`default_nettype none
// Bin memory read-modify-write with forwarding, clearing pass and output register
module mrfh_count import mrfh_pkg::*; #(
    parameter int NUM_BINS   = DEF_NUM_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_req_valid,
    input  t_req       i_req,
    output logic       o_req_ready,
    output logic       o_busy,
    mrfh_out_if.source o_result
);

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // clearing pass
    logic                  r_clr;
    logic [ADDR_W-1:0]     r_clr_addr;

    // read stage
    logic                  r_b_valid;
    t_req                  r_b;
    logic [ADDR_W-1:0]     b_addr;

    // last write seen by the read now in the read stage
    logic                  r_fwd_valid;
    logic [ADDR_W-1:0]     r_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_data;

    // output register
    logic                     r_out_valid;
    logic [INDEX_W-1:0]       r_out_index;
    logic [COUNT_FIELD_W-1:0] r_out_count;
    logic                     r_out_bad;

    logic                  out_free;
    logic                  b_free;
    logic                  wr_item;
    logic [COUNT_BITS-1:0] rdata;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS-1:0] res_cnt;
    logic [CNT_EXT_W-1:0]  res_ext;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [COUNT_BITS-1:0] wdata;

    assign out_free    = !r_out_valid || o_result.ready;
    assign b_free      = !r_b_valid || out_free;
    assign o_req_ready = b_free;
    assign o_busy      = r_clr;
    assign b_addr      = r_b.idx[ADDR_W-1:0];
    assign wr_item     = r_b_valid && out_free && (r_b.op == OP_COUNT) && !r_b.bad;

    // clear every entry once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(NUM_BINS - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    // saturating increment with forwarding of the write that raced our read
    always_comb begin
        cur   = (r_fwd_valid && (r_fwd_addr == b_addr)) ? r_fwd_data : rdata;
        n_cnt = (cur == CNT_MAX) ? cur : cur + COUNT_BITS'(1);
        if (r_b.bad) begin
            res_cnt = '0;
        end else if (r_b.op == OP_READ) begin
            res_cnt = cur;
        end else begin
            res_cnt = n_cnt;
        end
        res_ext = CNT_EXT_W'(res_cnt);
    end

    assign we    = r_clr || wr_item;
    assign waddr = r_clr ? r_clr_addr : b_addr;
    assign wdata = r_clr ? '0 : n_cnt;

    mrfh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (b_free),
        .i_raddr (i_req.idx[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid   <= i_req_valid;
            r_fwd_valid <= wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free) begin
            r_fwd_addr <= b_addr;
            r_fwd_data <= n_cnt;
            if (i_req_valid) begin
                r_b <= i_req;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_b_valid) begin
            r_out_index <= r_b.idx[INDEX_W-1:0];
            r_out_count <= res_ext[COUNT_FIELD_W-1:0];
            r_out_bad   <= r_b.bad;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.bin_index = r_out_index;
    assign o_result.bin_count = r_out_count;
    assign o_result.bad_value = r_out_bad;

    a_idle_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> (!r_b_valid && !r_out_valid))
        else $error("item in flight during clearing pass");

    a_count_write_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && !r_clr) |-> (wdata != '0))
        else $error("count write of zero");

    a_write_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_item |-> (r_b.idx < IDX_W'(NUM_BINS)))
        else $error("count write beyond table");

endmodule
`default_nettype wire
